// ===== rtl/cll_pkg.sv =====
// Shared types and codes for the cursor linked list store.
// Holds request/response structs, op and status codes, parameter defaults.
// No dependencies.
package cll_pkg;

  // parameter defaults
  localparam int unsigned POOL_NODES_DEF = 256;
  localparam int unsigned MAX_LISTS_DEF  = 16;
  localparam int unsigned VALUE_BITS_DEF = 32;

  // operation codes
  localparam logic [2:0] OP_CREATE = 3'd0;
  localparam logic [2:0] OP_APPEND = 3'd1;
  localparam logic [2:0] OP_INSERT = 3'd2;
  localparam logic [2:0] OP_DELETE = 3'd3;
  localparam logic [2:0] OP_READ   = 3'd4;

  // status codes
  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_BADLIST  = 2'd3;

  typedef struct packed {
    logic [2:0]  op;
    logic [3:0]  list_number;
    logic [31:0] key_value;
    logic [31:0] new_value;
    logic [7:0]  node_select;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [8:0]  node_used;
    logic [31:0] node_data;
    logic [8:0]  next_link;
    logic [4:0]  lists_in_use;
  } rsp_t;

endpackage

// ===== rtl/cursor_linked_list_store.sv =====
// Cursor linked list store: several singly linked lists share one node pool
// kept in a single RAM (value and link per word) plus a free chain. After
// reset the block is busy while it sweeps the pool to build the free chain.
// A request is taken when start is high and busy is low; the response strobe
// follows once the operation ends and must be captured in that cycle. A
// request rejected at decode is answered without a pool access; append,
// insert-before and delete walk the list node by node through the single
// RAM read port.
// Depends on cll_pkg and cll_ram.
module cursor_linked_list_store #(
  parameter int unsigned POOL_NODES = cll_pkg::POOL_NODES_DEF,
  parameter int unsigned MAX_LISTS  = cll_pkg::MAX_LISTS_DEF,
  parameter int unsigned VALUE_BITS = cll_pkg::VALUE_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  cll_pkg::req_t req_i,
  output logic          rsp_valid_o,
  output cll_pkg::rsp_t rsp_o
);

  localparam int unsigned AW = $clog2(POOL_NODES);
  localparam int unsigned LW = AW + 1;
  localparam int unsigned HW = (MAX_LISTS > 1) ? $clog2(MAX_LISTS) : 1;
  localparam int unsigned CW = $clog2(MAX_LISTS + 1);
  localparam int unsigned VW = VALUE_BITS;
  localparam int unsigned WW = VW + LW;
  localparam logic [LW-1:0] NO_NODE = LW'(POOL_NODES);

  // sequencer states
  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_WALK  = 3'd2;
  localparam logic [2:0] S_TAKE  = 3'd3;
  localparam logic [2:0] S_WR2   = 3'd4;
  localparam logic [2:0] S_DELWR = 3'd5;
  localparam logic [2:0] S_RDN   = 3'd6;

  function automatic logic [8:0] to9(logic [LW-1:0] x);
    logic [31:0] w;
    w = 32'(x);
    return w[8:0];
  endfunction

  function automatic logic [4:0] to5(logic [CW-1:0] x);
    logic [31:0] w;
    w = 32'(x);
    return w[4:0];
  endfunction

  logic [2:0]    state_q, state_d;
  logic [AW-1:0] init_q, init_d;
  logic [LW-1:0] fh_q, fh_d;
  logic [CW-1:0] count_q, count_d;
  logic          rsp_valid_q, rsp_valid_d;
  cll_pkg::rsp_t rsp_q, rsp_d;

  logic [2:0]    op_q, op_d;
  logic [HW-1:0] hidx_q, hidx_d;
  logic [VW-1:0] tgt_q, tgt_d;
  logic [VW-1:0] val_q, val_d;
  logic [LW-1:0] cur_q, cur_d;
  logic [LW-1:0] before_q, before_d;
  logic [VW-1:0] bval_q, bval_d;
  logic [LW-1:0] head_q, head_d;
  logic [LW-1:0] node_q, node_d;
  logic          found_q, found_d;

  logic [LW-1:0] heads_q [MAX_LISTS];
  logic          head_we;
  logic [HW-1:0] head_widx;
  logic [LW-1:0] head_wdata;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [WW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [WW-1:0] ram_rdata;
  logic [VW-1:0] rd_val;
  logic [LW-1:0] rd_link;
  logic [63:0]   rd64;

  logic [63:0]   nv64, kv64;
  logic [31:0]   ln32, sel32, cnt32;
  logic [HW-1:0] ln_idx, cnt_idx;
  logic          list_ok, sel_ok;
  logic [LW-1:0] head_sel;

  // node pool: {value, link}
  cll_ram #(
    .WIDTH(WW),
    .DEPTH(POOL_NODES)
  ) u_pool (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign rd_val  = ram_rdata[WW-1:LW];
  assign rd_link = ram_rdata[LW-1:0];
  assign rd64    = 64'(rd_val);

  // request decode
  assign nv64     = 64'(req_i.new_value);
  assign kv64     = 64'(req_i.key_value);
  assign ln32     = 32'(req_i.list_number);
  assign sel32    = 32'(req_i.node_select);
  assign cnt32    = 32'(count_q);
  assign ln_idx   = ln32[HW-1:0];
  assign cnt_idx  = cnt32[HW-1:0];
  assign list_ok  = ln32 < cnt32;
  assign sel_ok   = sel32 < 32'(POOL_NODES);
  assign head_sel = list_ok ? heads_q[ln_idx] : NO_NODE;

  // sequencer
  always_comb begin
    state_d     = state_q;
    init_d      = init_q;
    fh_d        = fh_q;
    count_d     = count_q;
    rsp_valid_d = 1'b0;
    rsp_d       = rsp_q;
    op_d        = op_q;
    hidx_d      = hidx_q;
    tgt_d       = tgt_q;
    val_d       = val_q;
    cur_d       = cur_q;
    before_d    = before_q;
    bval_d      = bval_q;
    head_d      = head_q;
    node_d      = node_q;
    found_d     = found_q;
    ram_we      = 1'b0;
    ram_waddr   = cur_q[AW-1:0];
    ram_wdata   = '0;
    ram_raddr   = cur_q[AW-1:0];
    head_we     = 1'b0;
    head_widx   = hidx_q;
    head_wdata  = node_q;

    case (state_q)
      // sweep the pool: value zero, link to the next entry
      S_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = init_q;
        ram_wdata = {{VW{1'b0}}, LW'(init_q) + LW'(1)};
        init_d    = init_q + AW'(1);
        if (init_q == AW'(POOL_NODES - 1)) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (start) begin
          op_d     = req_i.op;
          hidx_d   = ln_idx;
          val_d    = nv64[VW-1:0];
          tgt_d    = (req_i.op == cll_pkg::OP_DELETE) ? nv64[VW-1:0] : kv64[VW-1:0];
          head_d   = head_sel;
          cur_d    = head_sel;
          before_d = NO_NODE;
          found_d  = 1'b0;
          rsp_d.status       = cll_pkg::ST_NOTFOUND;
          rsp_d.node_used    = to9(NO_NODE);
          rsp_d.node_data    = '0;
          rsp_d.next_link    = to9(NO_NODE);
          rsp_d.lists_in_use = to5(count_q);
          case (req_i.op)
            cll_pkg::OP_CREATE: begin
              if (cnt32 >= 32'(MAX_LISTS)) begin
                rsp_d.status = cll_pkg::ST_BADLIST;
                rsp_valid_d  = 1'b1;
              end else if (fh_q == NO_NODE) begin
                rsp_d.status = cll_pkg::ST_FULL;
                rsp_valid_d  = 1'b1;
              end else begin
                ram_raddr = fh_q[AW-1:0];
                state_d   = S_TAKE;
              end
            end
            cll_pkg::OP_APPEND, cll_pkg::OP_INSERT: begin
              if (!list_ok) begin
                rsp_d.status = cll_pkg::ST_BADLIST;
                rsp_valid_d  = 1'b1;
              end else if (fh_q == NO_NODE) begin
                rsp_d.status = cll_pkg::ST_FULL;
                rsp_valid_d  = 1'b1;
              end else begin
                ram_raddr = head_sel[AW-1:0];
                state_d   = S_WALK;
              end
            end
            cll_pkg::OP_DELETE: begin
              if (!list_ok) begin
                rsp_d.status = cll_pkg::ST_BADLIST;
                rsp_valid_d  = 1'b1;
              end else begin
                ram_raddr = head_sel[AW-1:0];
                state_d   = S_WALK;
              end
            end
            cll_pkg::OP_READ: begin
              if (sel_ok) begin
                cur_d     = sel32[LW-1:0];
                ram_raddr = sel32[AW-1:0];
                state_d   = S_RDN;
              end else begin
                rsp_valid_d = 1'b1;
              end
            end
            default: begin
              rsp_valid_d = 1'b1;
            end
          endcase
        end
      end

      // one node per cycle: read data belongs to cur_q
      S_WALK: begin
        if (op_q != cll_pkg::OP_APPEND && rd_val == tgt_q) begin
          found_d = 1'b1;
          if (op_q == cll_pkg::OP_INSERT) begin
            ram_raddr = fh_q[AW-1:0];
            state_d   = S_TAKE;
          end else if (cur_q == head_q) begin
            if (rd_link != NO_NODE) begin
              head_we    = 1'b1;
              head_wdata = rd_link;
              state_d    = S_DELWR;
            end else begin
              // refuse to empty the list
              rsp_valid_d = 1'b1;
              state_d     = S_IDLE;
            end
          end else begin
            ram_we    = 1'b1;
            ram_waddr = before_q[AW-1:0];
            ram_wdata = {bval_q, rd_link};
            state_d   = S_DELWR;
          end
        end else if (rd_link == NO_NODE) begin
          if (op_q == cll_pkg::OP_DELETE) begin
            rsp_valid_d = 1'b1;
            state_d     = S_IDLE;
          end else begin
            // tail found: remember it for the link update
            before_d  = cur_q;
            bval_d    = rd_val;
            ram_raddr = fh_q[AW-1:0];
            state_d   = S_TAKE;
          end
        end else begin
          before_d  = cur_q;
          bval_d    = rd_val;
          cur_d     = rd_link;
          ram_raddr = rd_link[AW-1:0];
        end
      end

      // pop the free head and fill it
      S_TAKE: begin
        node_d          = fh_q;
        fh_d            = rd_link;
        ram_we          = 1'b1;
        ram_waddr       = fh_q[AW-1:0];
        ram_wdata       = {val_q, (found_q ? cur_q : NO_NODE)};
        rsp_d.node_used = to9(fh_q);
        rsp_d.status    = cll_pkg::ST_DONE;
        if (op_q == cll_pkg::OP_CREATE) begin
          head_we            = 1'b1;
          head_widx          = cnt_idx;
          head_wdata         = fh_q;
          count_d            = count_q + CW'(1);
          rsp_d.lists_in_use = to5(count_q + CW'(1));
          rsp_valid_d        = 1'b1;
          state_d            = S_IDLE;
        end else if (found_q && cur_q == head_q) begin
          head_we     = 1'b1;
          head_wdata  = fh_q;
          rsp_valid_d = 1'b1;
          state_d     = S_IDLE;
        end else begin
          state_d = S_WR2;
        end
      end

      // relink predecessor or tail to the new node
      S_WR2: begin
        ram_we      = 1'b1;
        ram_waddr   = before_q[AW-1:0];
        ram_wdata   = {bval_q, node_q};
        rsp_valid_d = 1'b1;
        state_d     = S_IDLE;
      end

      // return the removed node to the free chain
      S_DELWR: begin
        ram_we          = 1'b1;
        ram_waddr       = cur_q[AW-1:0];
        ram_wdata       = {{VW{1'b0}}, fh_q};
        fh_d            = cur_q;
        rsp_d.node_used = to9(cur_q);
        rsp_d.status    = cll_pkg::ST_DONE;
        rsp_valid_d     = 1'b1;
        state_d         = S_IDLE;
      end

      S_RDN: begin
        rsp_d.node_used = to9(cur_q);
        rsp_d.node_data = rd64[31:0];
        rsp_d.next_link = to9(rd_link);
        rsp_d.status    = cll_pkg::ST_DONE;
        rsp_valid_d     = 1'b1;
        state_d         = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      init_q      <= '0;
      fh_q        <= '0;
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      init_q      <= init_d;
      fh_q        <= fh_d;
      count_q     <= count_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    rsp_q    <= rsp_d;
    op_q     <= op_d;
    hidx_q   <= hidx_d;
    tgt_q    <= tgt_d;
    val_q    <= val_d;
    cur_q    <= cur_d;
    before_q <= before_d;
    bval_q   <= bval_d;
    head_q   <= head_d;
    node_q   <= node_d;
    found_q  <= found_d;
    if (head_we) begin
      heads_q[head_widx] <= head_wdata;
    end
  end

  assign busy        = state_q != S_IDLE;
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  // accepted request is either in progress or answered next cycle
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || rsp_valid_o))
    else $error("request neither in progress nor answered");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= 32'(MAX_LISTS))
    else $error("list count beyond limit");

  a_free_head_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fh_q <= NO_NODE)
    else $error("free head out of range");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !ram_we)
    else $error("pool written while idle");

endmodule

// ===== rtl/cll_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// Read returns the stored word before a same-cycle write. No dependencies.
module cll_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== tb/sv/tb_cursor_linked_list_store.sv =====
// Testbench for cursor_linked_list_store: drives list requests, predicts each
// response with an in-bench model of the node pool, and compares field by field.
// Depends on cll_pkg and the store RTL.
`timescale 1ns / 1ps
module tb_cursor_linked_list_store;

  localparam int unsigned POOL = 256;
  localparam int unsigned LISTS = 16;
  localparam logic [8:0] NONE = 9'd256;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  cll_pkg::req_t req_i = '0;
  logic rsp_valid_o;
  cll_pkg::rsp_t rsp_o;

  cursor_linked_list_store DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .req_i(req_i), .rsp_valid_o(rsp_valid_o), .rsp_o(rsp_o)
  );

  always #6 clk_i = ~clk_i;

  // predicted pool state
  logic [31:0] pool_val [POOL];
  logic [8:0]  pool_link [POOL];
  logic [8:0]  free_ptr;
  logic [8:0]  head_of [LISTS];
  logic [4:0]  made_lists;

  cll_pkg::rsp_t pending_rsp [$];
  int   err_count = 0;
  bit   calm = 1'b0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
    err_count++;
  endtask

  function automatic void pool_reset();
    for (int i = 0; i < POOL; i++) begin
      pool_val[i] = '0;
      pool_link[i] = 9'(i + 1);
    end
    free_ptr = '0;
    for (int i = 0; i < LISTS; i++) head_of[i] = '0;
    made_lists = '0;
  endfunction

  // first node holding v; prev gets its predecessor
  function automatic logic [8:0] seek_value(input logic [8:0] hd, input logic [31:0] v,
                                            output logic [8:0] prev);
    logic [8:0] cur;
    logic [8:0] bf;
    cur = hd;
    bf = NONE;
    prev = NONE;
    for (int s = 0; s < POOL && cur < NONE; s++) begin
      if (pool_val[cur] == v) begin
        prev = bf;
        return cur;
      end
      bf = cur;
      cur = pool_link[cur];
    end
    return NONE;
  endfunction

  function automatic logic [8:0] tail_of(input logic [8:0] hd);
    logic [8:0] cur;
    cur = hd;
    for (int s = 0; s < POOL && cur < NONE; s++) begin
      if (pool_link[cur] >= NONE) return cur;
      cur = pool_link[cur];
    end
    return cur;
  endfunction

  function automatic logic [8:0] grab_node(input logic [31:0] v);
    logic [8:0] n;
    n = free_ptr;
    free_ptr = pool_link[n];
    pool_val[n] = v;
    pool_link[n] = NONE;
    return n;
  endfunction

  // apply one request to the predicted pool and return the response
  function automatic cll_pkg::rsp_t predict_store(input cll_pkg::req_t r);
    cll_pkg::rsp_t o;
    logic [8:0] hd, pos, prev, nx, last;
    logic list_ok;
    o = '0;
    o.status = cll_pkg::ST_NOTFOUND;
    o.node_used = NONE;
    o.next_link = NONE;
    list_ok = {1'b0, r.list_number} < made_lists;
    if (r.op == cll_pkg::OP_CREATE) begin
      if (made_lists >= LISTS) o.status = cll_pkg::ST_BADLIST;
      else if (free_ptr >= NONE) o.status = cll_pkg::ST_FULL;
      else begin
        o.node_used = grab_node(r.new_value);
        head_of[made_lists[3:0]] = o.node_used;
        made_lists++;
        o.status = cll_pkg::ST_DONE;
      end
    end else if ((r.op == cll_pkg::OP_APPEND || r.op == cll_pkg::OP_INSERT ||
                  r.op == cll_pkg::OP_DELETE) && !list_ok) begin
      o.status = cll_pkg::ST_BADLIST;
    end else if (r.op == cll_pkg::OP_APPEND || r.op == cll_pkg::OP_INSERT) begin
      if (free_ptr >= NONE) o.status = cll_pkg::ST_FULL;
      else begin
        hd = head_of[r.list_number];
        pos = NONE;
        prev = NONE;
        if (r.op == cll_pkg::OP_INSERT) pos = seek_value(hd, r.key_value, prev);
        o.node_used = grab_node(r.new_value);
        if (pos >= NONE) begin
          last = tail_of(hd);
          if (last < NONE) pool_link[last] = o.node_used;
        end else if (pos == hd) begin
          pool_link[o.node_used] = pos;
          head_of[r.list_number] = o.node_used;
        end else begin
          pool_link[o.node_used] = pos;
          if (prev < NONE) pool_link[prev] = o.node_used;
        end
        o.status = cll_pkg::ST_DONE;
      end
    end else if (r.op == cll_pkg::OP_DELETE) begin
      hd = head_of[r.list_number];
      pos = seek_value(hd, r.new_value, prev);
      if (pos < NONE) begin
        nx = pool_link[pos];
        if (pos == hd) begin
          if (nx < NONE) begin
            head_of[r.list_number] = nx;
            o.status = cll_pkg::ST_DONE;
          end
        end else if (prev < NONE) begin
          pool_link[prev] = nx;
          o.status = cll_pkg::ST_DONE;
        end
        if (o.status == cll_pkg::ST_DONE) begin
          pool_val[pos] = '0;
          pool_link[pos] = free_ptr;
          free_ptr = pos;
          o.node_used = pos;
        end
      end
    end else if (r.op == cll_pkg::OP_READ) begin
      o.node_used = {1'b0, r.node_select};
      o.node_data = pool_val[r.node_select];
      o.next_link = pool_link[r.node_select];
      o.status = cll_pkg::ST_DONE;
    end
    o.lists_in_use = made_lists;
    return o;
  endfunction

  // send one request: random gap unless calm, wait for acceptance, predict;
  // start stays up after return so the next request can follow directly
  task automatic send_request(input cll_pkg::req_t r);
    if (!calm) while ($urandom_range(99) < 16) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    req_i <= r;
    start <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pending_rsp.push_back(predict_store(r));
    @(negedge clk_i);
  endtask

  // response checker
  always @(posedge clk_i) begin
    if (rst_ni && rsp_valid_o) begin
      if (pending_rsp.size() == 0) begin
        report_mismatch("unexpected response", 32'(rsp_o), '0);
      end else begin
        cll_pkg::rsp_t w;
        w = pending_rsp.pop_front();
        if (rsp_o.status !== w.status)
          report_mismatch("status", 32'(rsp_o.status), 32'(w.status));
        if (rsp_o.node_used !== w.node_used)
          report_mismatch("node_used", 32'(rsp_o.node_used), 32'(w.node_used));
        if (rsp_o.node_data !== w.node_data)
          report_mismatch("node_data", rsp_o.node_data, w.node_data);
        if (rsp_o.next_link !== w.next_link)
          report_mismatch("next_link", 32'(rsp_o.next_link), 32'(w.next_link));
        if (rsp_o.lists_in_use !== w.lists_in_use)
          report_mismatch("lists_in_use", 32'(rsp_o.lists_in_use),
                          32'(w.lists_in_use));
      end
    end
  end

  function automatic cll_pkg::req_t make_req(input logic [2:0] op, input logic [3:0] ln,
                                             input logic [31:0] key,
                                             input logic [31:0] val,
                                             input logic [7:0] sel);
    cll_pkg::req_t r;
    r.op = op;
    r.list_number = ln;
    r.key_value = key;
    r.new_value = val;
    r.node_select = sel;
    return r;
  endfunction

  // values drawn from a small set so searches hit, sometimes extreme
  function automatic logic [31:0] pick_value();
    case ($urandom_range(9))
      0: return $urandom();
      1: return 32'hFFFF_FFFF;
      default: return 32'($urandom_range(7));
    endcase
  endfunction

  // edge cases before any list exists, extremes, every op
  task automatic test_directed();
    send_request(make_req(cll_pkg::OP_APPEND, 4'd0, '0, 32'd5, '0));
    send_request(make_req(cll_pkg::OP_DELETE, 4'd15, '0, 32'd5, '0));
    send_request(make_req(cll_pkg::OP_READ, 4'd3, '0, '0, 8'd255));
    send_request(make_req(cll_pkg::OP_READ, 4'd0, '0, '0, 8'd0));
    send_request(make_req(cll_pkg::OP_CREATE, 4'd9, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                          8'hFF));
    send_request(make_req(cll_pkg::OP_DELETE, 4'd0, '0, 32'hFFFF_FFFF, '0));
    send_request(make_req(cll_pkg::OP_APPEND, 4'd0, '0, 32'd1, '0));
    send_request(make_req(cll_pkg::OP_INSERT, 4'd0, 32'hFFFF_FFFF, 32'd2, '0));
    send_request(make_req(cll_pkg::OP_INSERT, 4'd0, 32'd1, 32'd3, '0));
    send_request(make_req(cll_pkg::OP_INSERT, 4'd0, 32'd77, 32'd4, '0));
    send_request(make_req(cll_pkg::OP_DELETE, 4'd0, '0, 32'd99, '0));
    send_request(make_req(cll_pkg::OP_DELETE, 4'd0, '0, 32'd1, '0));
    send_request(make_req(cll_pkg::OP_DELETE, 4'd0, '0, 32'd2, '0));
    send_request(make_req(cll_pkg::OP_READ, 4'd0, '0, '0, 8'd1));
    send_request(make_req(cll_pkg::OP_APPEND, 4'd1, '0, 32'd1, '0));
    send_request(make_req(3'd5, 4'd0, '0, '0, '0));
    send_request(make_req(3'd6, 4'd0, '0, '0, '0));
    send_request(make_req(3'd7, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF));
  endtask

  // fill all list slots, then create past the limit
  task automatic test_list_limit();
    while (made_lists < LISTS)
      send_request(make_req(cll_pkg::OP_CREATE, 4'($urandom()), '0,
                            pick_value(), '0));
    send_request(make_req(cll_pkg::OP_CREATE, 4'd0, '0, 32'd1, '0));
  endtask

  // exhaust the pool, then append/insert and delete around fullness
  task automatic test_pool_full();
    while (free_ptr < NONE)
      send_request(make_req(cll_pkg::OP_APPEND, 4'($urandom_range(LISTS - 1)), '0,
                            pick_value(), '0));
    send_request(make_req(cll_pkg::OP_APPEND, 4'd3, '0, 32'd1, '0));
    send_request(make_req(cll_pkg::OP_INSERT, 4'd4, 32'd1, 32'd1, '0));
    for (int i = 0; i < 200; i++)
      send_request(make_req(cll_pkg::OP_DELETE, 4'($urandom_range(LISTS - 1)), '0,
                            pick_value(), '0));
  endtask

  // random mix, mostly valid ops on existing lists
  task automatic test_random(input int n);
    cll_pkg::req_t r;
    for (int i = 0; i < n; i++) begin
      calm = (i >= n / 3 && i < n / 2);
      r.key_value = pick_value();
      r.new_value = pick_value();
      r.node_select = 8'($urandom());
      r.list_number = ($urandom_range(9) == 0) ? 4'($urandom())
                                               : 4'($urandom_range(LISTS - 1));
      case ($urandom_range(19))
        0: r.op = cll_pkg::OP_CREATE;
        1, 2, 3, 4, 5: r.op = cll_pkg::OP_APPEND;
        6, 7, 8, 9: r.op = cll_pkg::OP_INSERT;
        10, 11, 12, 13, 14, 15: r.op = cll_pkg::OP_DELETE;
        16, 17, 18: r.op = cll_pkg::OP_READ;
        default: r.op = 3'($urandom_range(7));
      endcase
      send_request(r);
    end
    calm = 1'b0;
  endtask

  initial begin
    pool_reset();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_list_limit();
    test_pool_full();
    test_random(1700);
    start <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (err_count == 0) begin
      $display("tb_cursor_linked_list_store: PASS");
    end else begin
      $display("tb_cursor_linked_list_store: FAIL");
    end
    $finish;
  end

  // watchdog: bounds a run of ~2300 requests on a 12 ns clock, with margin
  initial begin
    #50ms;
    $display("tb_cursor_linked_list_store: FAIL");
    $finish;
  end

endmodule
